FILE: hw/rtl/fcjs_pkg.sv
`timescale 1ns / 1ps

package fcjs_pkg;

  // Table geometry and limits
  localparam int CLUSTERS  = 4096;
  localparam int MAX_FILES = 256;
  localparam int MAX_JOBS  = 64;
  localparam int ADDR_W    = $clog2(CLUSTERS);
  localparam int STEP_W    = $clog2(CLUSTERS + 1);

  // Field widths
  localparam int ENTRY_W  = 16;
  localparam int INDEX_W  = 12;
  localparam int FILE_W   = 8;
  localparam int TS_W     = 13;
  localparam int TARGET_W = 12;
  localparam int JOBS_W   = 7;
  localparam int TDATA_W  = 56;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 3;

  // Job size limits
  localparam logic [TS_W-1:0] TS_MIN = 13'd64;
  localparam logic [TS_W-1:0] TS_MAX = 13'd4096;

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SCAN = 1'b1;

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_TASK_SIZE     = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_DEFRAG_MODE   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_END_MARKER    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_UNUSED_MARKER = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_BAD_MARKER    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STEP
  } ctl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // write one table entry
    logic start;      // begin a chain walk
    logic step;       // take the read data as the next cluster
    logic emit_pend;  // send the held full segment
    logic emit_tail;  // send the partial or empty final segment
    logic last;       // final job of the walk
    logic err;        // walk was cut off
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic file_ok;     // scanned file is in range
    logic is_marker;   // current cluster is a chain marker
    logic is_fault;    // out of table, step limit or job limit
    logic pend_valid;  // a full segment waits for its last flag
    logic tail_nz;     // clusters gathered since the last segment
    logic n_zero;      // no job created yet
    logic out_free;    // output register can take a job
  } dp_stat_t;

endpackage

FILE: hw/rtl/fat_chain_job_splitter.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// in        in   in_tvalid/tready     tuser: req_type; tdata: entry_index, entry_value,
//                                     file_number, chain_head
// out       out  out_tvalid/tready    tdata: job_file, job_first, job_length, job_target;
//                                     tuser: chain_error; tlast: last
// cfg       in   cfg_wr_en            cfg_addr register index, cfg_wr_data value
//
// A load writes one table entry. A scan checks the current cluster, then steps to the
// next one through the registered FAT read, and repeats for each cluster of the chain.
// rst_n is synchronous and clears control state and configuration; FAT contents
// are kept as they are. One job sits in the output register; while it is not
// taken the walk waits at its check step.

module fat_chain_job_splitter
  import fcjs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // entry_index, entry_value, file_number, chain_head
  input  logic               in_tuser,   // req_type
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // job_file, job_first, job_length, job_target
  output logic               out_tuser,  // chain_error
  output logic               out_tlast,
  input  logic               cfg_wr_en,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wr_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  logic [FILE_W-1:0]   job_file;
  logic [ENTRY_W-1:0]  job_first;
  logic [TS_W-1:0]     job_length;
  logic [TARGET_W-1:0] job_target;

  fcjs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_req_type (in_tuser),
    .in_tready   (in_tready),
    .stat        (stat),
    .cmd         (cmd)
  );

  fcjs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_entry_index  (in_tdata[11:0]),
    .in_entry_value  (in_tdata[27:12]),
    .in_file_number  (in_tdata[35:28]),
    .in_chain_head   (in_tdata[51:36]),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_wr_data     (cfg_wr_data),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_job_file    (job_file),
    .out_job_first   (job_first),
    .out_job_length  (job_length),
    .out_job_target  (job_target),
    .out_chain_error (out_tuser),
    .out_last        (out_tlast)
  );

  // Pack the job fields
  assign out_tdata = {7'd0, job_target, job_length, job_first, job_file};

endmodule

FILE: hw/rtl/fcjs_ram.sv
`timescale 1ns / 1ps

module fcjs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with a registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/fcjs_datapath.sv
`timescale 1ns / 1ps

module fcjs_datapath
  import fcjs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  input  logic [INDEX_W-1:0]  in_entry_index,
  input  logic [ENTRY_W-1:0]  in_entry_value,
  input  logic [FILE_W-1:0]   in_file_number,
  input  logic [ENTRY_W-1:0]  in_chain_head,
  input  logic                cfg_wr_en,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [FILE_W-1:0]   out_job_file,
  output logic [ENTRY_W-1:0]  out_job_first,
  output logic [TS_W-1:0]     out_job_length,
  output logic [TARGET_W-1:0] out_job_target,
  output logic                out_chain_error,
  output logic                out_last
);

  // Configuration registers
  logic [TS_W-1:0]    task_size_r;
  logic               defrag_mode_r;
  logic [ENTRY_W-1:0] end_marker_r;
  logic [ENTRY_W-1:0] unused_marker_r;
  logic [ENTRY_W-1:0] bad_marker_r;

  // Walk state
  logic [TS_W-1:0]     ts_r;
  logic [FILE_W-1:0]   file_r;
  logic [ENTRY_W-1:0]  curr_r;
  logic [ENTRY_W-1:0]  first_r;
  logic [TS_W-1:0]     cnt_r;
  logic [STEP_W-1:0]   steps_r;
  logic [JOBS_W-1:0]   n_r;
  logic [TARGET_W-1:0] tgt_r;
  logic                pend_valid_r;
  logic [ENTRY_W-1:0]  pend_first_r;
  logic [TARGET_W-1:0] pend_tgt_r;

  logic [TS_W-1:0]    ts_clamped;
  logic [TS_W-1:0]    cnt_inc;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_ok;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_size_r     <= TS_MIN;
      defrag_mode_r   <= 1'b0;
      end_marker_r    <= 16'hFFFF;
      unused_marker_r <= 16'hFFFE;
      bad_marker_r    <= 16'hFFFD;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_TASK_SIZE:     task_size_r     <= cfg_wr_data[TS_W-1:0];
        CFG_DEFRAG_MODE:   defrag_mode_r   <= cfg_wr_data[0];
        CFG_END_MARKER:    end_marker_r    <= cfg_wr_data;
        CFG_UNUSED_MARKER: unused_marker_r <= cfg_wr_data;
        CFG_BAD_MARKER:    bad_marker_r    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Saturate the job size
  always_comb begin
    if (task_size_r < TS_MIN) begin
      ts_clamped = TS_MIN;
    end else if (task_size_r > TS_MAX) begin
      ts_clamped = TS_MAX;
    end else begin
      ts_clamped = task_size_r;
    end
  end

  // FAT storage
  assign wr_ok = int'(in_entry_index) < CLUSTERS;

  fcjs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CLUSTERS)
  ) u_fat (
    .clk     (clk),
    .wr_en   (cmd.load && wr_ok),
    .wr_addr (ADDR_W'(in_entry_index)),
    .wr_data (in_entry_value),
    .rd_addr (curr_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign cnt_inc = cnt_r + 1'b1;

  // Status toward the controller
  always_comb begin
    stat.file_ok    = int'(in_file_number) < MAX_FILES;
    stat.is_marker  = (curr_r == end_marker_r) || (curr_r == unused_marker_r) ||
                      (curr_r == bad_marker_r);
    stat.is_fault   = ({1'b0, curr_r} >= 17'(CLUSTERS)) ||
                      (steps_r >= STEP_W'(CLUSTERS)) ||
                      (n_r >= JOBS_W'(MAX_JOBS));
    stat.pend_valid = pend_valid_r;
    stat.tail_nz    = cnt_r != '0;
    stat.n_zero     = n_r == '0;
    stat.out_free   = !out_tvalid || out_tready;
  end

  // Start, advance and cut the walk into segments
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r         <= TS_MIN;
      cnt_r        <= '0;
      steps_r      <= '0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        ts_r         <= ts_clamped;
        file_r       <= in_file_number;
        curr_r       <= in_chain_head;
        first_r      <= in_chain_head;
        cnt_r        <= '0;
        steps_r      <= '0;
        n_r          <= '0;
        tgt_r        <= '0;
        pend_valid_r <= 1'b0;
      end else begin
        if (cmd.emit_pend) begin
          pend_valid_r <= 1'b0;
        end
        if (cmd.step) begin
          curr_r  <= rd_data;
          steps_r <= steps_r + 1'b1;
          if (cnt_inc == ts_r) begin
            pend_valid_r <= 1'b1;
            pend_first_r <= first_r;
            pend_tgt_r   <= tgt_r;
            tgt_r        <= tgt_r + ts_r[TARGET_W-1:0];
            n_r          <= n_r + 1'b1;
            first_r      <= rd_data;
            cnt_r        <= '0;
          end else begin
            cnt_r <= cnt_inc;
          end
        end
      end
    end
  end

  // Load the output register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.emit_pend || cmd.emit_tail) begin
      out_tvalid      <= 1'b1;
      out_job_file    <= file_r;
      out_chain_error <= cmd.err;
      out_last        <= cmd.last;
      if (cmd.emit_pend) begin
        out_job_first  <= pend_first_r;
        out_job_length <= ts_r;
        out_job_target <= defrag_mode_r ? pend_tgt_r : '0;
      end else begin
        out_job_first  <= first_r;
        out_job_length <= cnt_r;
        out_job_target <= defrag_mode_r ? tgt_r : '0;
      end
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  a_pend_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> cnt_r == '0)
    else $error("held segment with clusters gathered after it");

  a_cnt_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < ts_r)
    else $error("segment count reached the job size");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_pend || cmd.emit_tail) |-> (!out_tvalid || out_tready))
    else $error("job emitted over an untaken job");

  a_jobs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= JOBS_W'(MAX_JOBS))
    else $error("job count beyond limit");

endmodule

FILE: hw/rtl/fcjs_ctrl.sv
`timescale 1ns / 1ps

module fcjs_ctrl
  import fcjs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_req_type,
  output logic     in_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       accept;

  assign in_tready = state_r == ST_IDLE;
  assign accept    = in_tvalid && in_tready;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_req_type == REQ_SCAN && stat.file_ok) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.out_free) begin
          state_nxt = (stat.is_marker || stat.is_fault) ? ST_IDLE : ST_STEP;
        end
      end
      ST_STEP: state_nxt = ST_CHECK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load  = accept && in_req_type == REQ_LOAD;
        cmd.start = accept && in_req_type == REQ_SCAN && stat.file_ok;
      end
      ST_CHECK: begin
        if (stat.out_free) begin
          if (stat.is_marker) begin
            // chain ends cleanly
            cmd.last      = 1'b1;
            cmd.emit_pend = stat.pend_valid;
            cmd.emit_tail = !stat.pend_valid && stat.tail_nz;
          end else if (stat.is_fault) begin
            // walk cut off: flag the final job, or an empty one if none
            cmd.last      = 1'b1;
            cmd.err       = 1'b1;
            cmd.emit_pend = stat.pend_valid;
            cmd.emit_tail = !stat.pend_valid && (stat.tail_nz || stat.n_zero);
          end else begin
            // chain goes on: a held segment is not the last one
            cmd.emit_pend = stat.pend_valid;
          end
        end
      end
      ST_STEP: cmd.step = 1'b1;
      default: ;
    endcase
  end

  a_tail_excludes_pend: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_pend && cmd.emit_tail))
    else $error("two jobs emitted in one cycle");

  a_step_follows_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> $past(state_r) == ST_CHECK)
    else $error("step without a preceding check");

endmodule

FILE: test/tb_fat_chain_job_splitter.sv
`timescale 1ns / 1ps

module tb_fat_chain_job_splitter;
  import fcjs_pkg::*;

  localparam int IN_PAD   = TDATA_W - 2 * ENTRY_W - INDEX_W - FILE_W;
  localparam int LANE_LEN = 65;   // clusters in the prebuilt lane at the table start
  localparam int SETTLE   = 32;   // cycles for a walk that ends without a job
  localparam logic [ENTRY_W-1:0] END_DEFAULT    = 16'hFFFF;
  localparam logic [ENTRY_W-1:0] UNUSED_DEFAULT = 16'hFFFE;
  localparam logic [ENTRY_W-1:0] BAD_DEFAULT    = 16'hFFFD;

  typedef struct packed {
    logic [FILE_W-1:0]   file;
    logic [ENTRY_W-1:0]  first;
    logic [TS_W-1:0]     length;
    logic [TARGET_W-1:0] target;
    logic                err;
    logic                last;
  } job_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;
  logic               out_tlast;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;

  // Shadow copy of the table and the registers
  logic [ENTRY_W-1:0] fat_model [CLUSTERS];
  bit                 written [CLUSTERS];
  logic [INDEX_W-1:0] written_list[$];
  logic [TS_W-1:0]    task_size_r = TS_MIN;
  logic               defrag_r = 1'b0;
  logic [ENTRY_W-1:0] end_r = END_DEFAULT;
  logic [ENTRY_W-1:0] unused_r = UNUSED_DEFAULT;
  logic [ENTRY_W-1:0] bad_r = BAD_DEFAULT;

  job_t     pending_jobs[$];
  int       mismatches = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  logic [7:0] stall_tick = '0;
  rx_mode_t stall_mode = RX_OPEN;

  fat_chain_job_splitter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Receiver: switch stall pattern each time the 8-bit tick counter wraps
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick == '1) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    case (stall_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_tready <= stall_tick[3];
      default:     out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void report_job(input string what, input job_t want, input job_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: file/first/len/target/err/last want %0d/%0d/%0d/%0d/%0b/%0b",
               $time, what, want.file, want.first, want.length, want.target,
               want.err, want.last);
      $display("    got %0d/%0d/%0d/%0d/%0b/%0b", got.file, got.first, got.length,
               got.target, got.err, got.last);
    end
  endfunction

  // Compare each delivered job with the oldest expected one
  always @(posedge clk) begin
    job_t seen;
    job_t want;
    if (rst_n && out_tvalid && out_tready) begin
      {seen.target, seen.length, seen.first, seen.file} =
        out_tdata[FILE_W+ENTRY_W+TS_W+TARGET_W-1:0];
      seen.err  = out_tuser;
      seen.last = out_tlast;
      if (pending_jobs.size() == 0) begin
        report_job("job with none expected", '0, seen);
      end else begin
        want = pending_jobs.pop_front();
        if (seen !== want) begin
          report_job("job mismatch", want, seen);
        end
      end
    end
  end

  function automatic logic [ENTRY_W-1:0] lane_next(input int idx);
    return (idx % LANE_LEN == LANE_LEN - 1) ? END_DEFAULT : ENTRY_W'(idx + 1);
  endfunction

  function automatic job_t make_job(input logic [FILE_W-1:0] file, input int unsigned first,
                                    input int unsigned len, input int unsigned slot,
                                    input int unsigned seg);
    job_t j;
    j.file   = file;
    j.first  = first[ENTRY_W-1:0];
    j.length = len[TS_W-1:0];
    j.target = defrag_r ? TARGET_W'(slot * seg) : '0;
    j.err    = 1'b0;
    j.last   = 1'b0;
    return j;
  endfunction

  // Follow the chain through the shadow table and queue the jobs it splits into
  function automatic void walk_chain(input logic [FILE_W-1:0] file,
                                     input logic [ENTRY_W-1:0] head);
    int unsigned seg;
    int unsigned curr;
    int unsigned first;
    int unsigned cnt;
    int unsigned steps;
    bit cut;
    job_t jobs[$];
    if (file >= MAX_FILES) return;
    seg = task_size_r;
    if (seg < TS_MIN) seg = TS_MIN;
    if (seg > TS_MAX) seg = TS_MAX;
    curr  = head;
    first = head;
    cnt   = 0;
    steps = 0;
    cut   = 1'b0;
    forever begin
      // markers win over the bounds test
      if (curr == end_r || curr == unused_r || curr == bad_r) break;
      if (curr >= CLUSTERS || steps >= CLUSTERS || jobs.size() >= MAX_JOBS) begin
        cut = 1'b1;
        break;
      end
      curr = fat_model[curr];
      steps++;
      cnt++;
      if (cnt == seg) begin
        jobs.push_back(make_job(file, first, cnt, jobs.size(), seg));
        first = curr;
        cnt   = 0;
      end
    end
    if (cnt != 0) jobs.push_back(make_job(file, first, cnt, jobs.size(), seg));
    // cut off before any cluster: one empty job that reports the fault
    if (jobs.size() == 0 && cut) jobs.push_back(make_job(file, head, 0, 0, seg));
    if (jobs.size() != 0) begin
      jobs[jobs.size()-1].err  = cut;
      jobs[jobs.size()-1].last = 1'b1;
    end
    foreach (jobs[k]) pending_jobs.push_back(jobs[k]);
  endfunction

  // Send one item in bursts with random gaps; predict on acceptance
  task automatic send_item(input logic req, input logic [INDEX_W-1:0] idx,
                           input logic [ENTRY_W-1:0] val, input logic [FILE_W-1:0] file,
                           input logic [ENTRY_W-1:0] head);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{IN_PAD{1'b0}}, head, file, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (req == REQ_LOAD) begin
      fat_model[idx] = val;
      if (!written[idx]) begin
        written[idx] = 1'b1;
        written_list.push_back(idx);
      end
    end else begin
      walk_chain(file, head);
    end
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [ENTRY_W-1:0] val);
    send_item(REQ_LOAD, idx, val, FILE_W'($urandom), ENTRY_W'($urandom));
  endtask

  task automatic scan_file(input logic [FILE_W-1:0] file, input logic [ENTRY_W-1:0] head);
    send_item(REQ_SCAN, INDEX_W'($urandom), ENTRY_W'($urandom), file, head);
  endtask

  // Drop valid, let every expected job drain, then let the walk settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_jobs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= addr;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (addr)
      CFG_TASK_SIZE:     task_size_r = data[TS_W-1:0];
      CFG_DEFRAG_MODE:   defrag_r = data[0];
      CFG_END_MARKER:    end_r = data;
      CFG_UNUSED_MARKER: unused_r = data;
      CFG_BAD_MARKER:    bad_r = data;
      default: ;
    endcase
  endtask

  // Load one lane of linked clusters from entry 0, closed by the end marker
  task automatic test_table_fill();
    for (int i = 0; i < LANE_LEN; i++) load_entry(INDEX_W'(i), lane_next(i));
  endtask

  task automatic test_default_walks();
    scan_file(8'd0, 16'd64);           // one cluster
    scan_file(8'd255, 16'd1);          // ends exactly on a segment boundary
    scan_file(8'd17, 16'd0);           // one past the boundary
    scan_file(8'd19, END_DEFAULT);     // head is a marker: nothing
    scan_file(8'd20, UNUSED_DEFAULT);
    scan_file(8'd21, BAD_DEFAULT);
    scan_file(8'd22, 16'd4096);        // head outside the table
    scan_file(8'd23, 16'hFFFC);
    load_entry(12'd40, 16'd5000);      // chain leaves the table midway
    scan_file(8'd24, 16'd30);
    load_entry(12'd40, lane_next(40));
  endtask

  task automatic test_job_sizes();
    wait_idle();
    write_reg(CFG_TASK_SIZE, 16'd0);   // clamps up to 64
    write_reg(CFG_DEFRAG_MODE, 16'd1);
    scan_file(8'd1, 16'd0);
    wait_idle();
    write_reg(CFG_TASK_SIZE, 16'd100);
    scan_file(8'd2, 16'd0);
    wait_idle();
    write_reg(CFG_TASK_SIZE, 16'd4096);
    scan_file(8'd3, 16'd0);
    wait_idle();
    write_reg(CFG_TASK_SIZE, 16'hFFFF); // clamps down to 4096
    scan_file(8'd4, 16'd10);
    wait_idle();
    write_reg(CFG_TASK_SIZE, 16'd63);
    write_reg(CFG_DEFRAG_MODE, 16'd0);
    scan_file(8'd5, 16'd3);
  endtask

  task automatic test_marker_values();
    wait_idle();
    write_reg(CFG_END_MARKER, 16'd30);
    write_reg(CFG_UNUSED_MARKER, 16'd0);
    write_reg(CFG_BAD_MARKER, 16'd5000);
    load_entry(12'd40, 16'd5000);
    scan_file(8'd6, 16'd35);           // marker beyond the table ends cleanly
    scan_file(8'd7, 16'd5000);         // head is a marker beyond the table
    scan_file(8'd8, 16'd0);            // head is the unused marker
    scan_file(8'd9, 16'd10);           // end marker inside the table
    scan_file(8'd10, 16'd50);          // old end value now points outside
    wait_idle();
    write_reg(CFG_END_MARKER, 16'd0);
    write_reg(CFG_UNUSED_MARKER, 16'hFFFF);
    write_reg(CFG_BAD_MARKER, 16'hFFFF);
    scan_file(8'd11, 16'd60);
    scan_file(8'd12, 16'd0);
    wait_idle();
    write_reg(CFG_END_MARKER, END_DEFAULT);
    write_reg(CFG_UNUSED_MARKER, UNUSED_DEFAULT);
    write_reg(CFG_BAD_MARKER, BAD_DEFAULT);
    load_entry(12'd40, lane_next(40));
  endtask

  // A cluster that points to itself runs into the step and job limits
  task automatic test_walk_limits();
    wait_idle();
    write_reg(CFG_TASK_SIZE, 16'd4096);
    write_reg(CFG_DEFRAG_MODE, 16'd1);
    load_entry(12'd50, 16'd50);
    scan_file(8'd77, 16'd50);
    wait_idle();
    write_reg(CFG_TASK_SIZE, 16'd64);
    scan_file(8'd78, 16'd50);
    wait_idle();
    write_reg(CFG_TASK_SIZE, 16'd100);
    scan_file(8'd79, 16'd50);
    load_entry(12'd50, lane_next(50));
  endtask

  function automatic logic [ENTRY_W-1:0] pick_marker(input logic [ENTRY_W-1:0] dflt);
    return ($urandom_range(0, 3) == 0) ? ENTRY_W'($urandom) : dflt;
  endfunction

  // Pick a loaded cluster or a value past the table, so no walk reads a blank entry
  function automatic logic [ENTRY_W-1:0] pick_link();
    if ($urandom_range(0, 3) == 0) return ENTRY_W'($urandom_range(CLUSTERS, 16'hFFFF));
    return ENTRY_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  // Link a few random clusters, close the chain, then scan it
  task automatic run_chain();
    logic [INDEX_W-1:0] nodes[$];
    logic [ENTRY_W-1:0] tail;
    int len;
    len = $urandom_range(1, 4);
    repeat (len) nodes.push_back(INDEX_W'($urandom));
    for (int i = 0; i + 1 < len; i++) load_entry(nodes[i], ENTRY_W'(nodes[i+1]));
    case ($urandom_range(0, 3))
      0:       tail = end_r;
      1:       tail = unused_r;
      2:       tail = bad_r;
      default: tail = ENTRY_W'($urandom_range(CLUSTERS, 16'hFFFF));
    endcase
    // a marker inside the table must not leave a link to a blank entry
    if (tail < CLUSTERS && !written[tail[INDEX_W-1:0]]) begin
      tail = ENTRY_W'($urandom_range(CLUSTERS, 16'hFFFF));
    end
    load_entry(nodes[len-1], tail);
    scan_file(FILE_W'($urandom), ENTRY_W'(nodes[0]));
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    logic [CFG_W-1:0] size;
    repeat (2) begin
      wait_idle();
      case ($urandom_range(0, 2))
        0:       size = 16'd64;
        1:       size = CFG_W'($urandom_range(0, 300));
        default: size = CFG_W'($urandom);
      endcase
      write_reg(CFG_TASK_SIZE, size);
      write_reg(CFG_DEFRAG_MODE, CFG_W'($urandom_range(0, 1)));
      write_reg(CFG_END_MARKER, pick_marker(END_DEFAULT));
      write_reg(CFG_UNUSED_MARKER, pick_marker(UNUSED_DEFAULT));
      write_reg(CFG_BAD_MARKER, pick_marker(BAD_DEFAULT));
      start = items_sent;
      while (items_sent - start < 8) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          run_chain();
        end else if (pick < 8) begin
          scan_file(FILE_W'($urandom), pick_link());
        end else if (pick == 8) begin
          load_entry(INDEX_W'($urandom), pick_link());
        end else begin
          case ($urandom_range(0, 2))
            0:       scan_file(FILE_W'($urandom), end_r);
            1:       scan_file(FILE_W'($urandom), unused_r);
            default: scan_file(FILE_W'($urandom), bad_r);
          endcase
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_default_walks();
    test_job_sizes();
    test_marker_values();
    test_walk_limits();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("tb_fat_chain_job_splitter: done, clean");
    end else begin
      $display("tb_fat_chain_job_splitter: done, errors");
    end
    $finish;
  end

  // Hard stop for a hung handshake or a missing job
  initial begin
    #100_000_000;
    $display("tb_fat_chain_job_splitter: done, errors");
    $finish;
  end

endmodule
